@@ rtl/cdgm_pkg.sv @@
// Shared constants and types for the central difference gradient magnitude block.
`timescale 1ns / 1ps

package cdgm_pkg;

  localparam int unsigned CFG_W    = 11;  // frame size register width
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned DIFF_W   = PIX_W + 1;
  localparam int unsigned SQ_W     = 2 * PIX_W;
  localparam int unsigned SUM_W    = SQ_W + 1;
  localparam int unsigned MAG_W    = 9;
  localparam int unsigned RAD_W    = 2 * MAG_W;
  localparam int unsigned MIN_SIZE = 3;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // 4-neighborhood around one interior pixel
  typedef struct packed {
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] down;
    logic             frame_end;
  } win_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             frame_end;
  } sum_t;

endpackage

@@ rtl/cdgm_line_buf.sv @@
// Raster counters, two line memories and the neighborhood window stage.
`timescale 1ns / 1ps

module cdgm_line_buf #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [cdgm_pkg::CFG_W-1:0] frame_width_i,
  input  logic [cdgm_pkg::CFG_W-1:0] frame_height_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [cdgm_pkg::PIX_W-1:0] pixel_i,
  output logic                       win_valid_o,
  input  logic                       win_ready_i,
  output cdgm_pkg::win_t             win_o
);
  import cdgm_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CW    = ((WW > CFG_W) ? WW : CFG_W) + 1;
  localparam int CHW   = ((HW > CFG_W) ? HW : CFG_W) + 1;

  logic [PIX_W-1:0] older_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] recent_mem [MAX_WIDTH];

  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_nxt;
  logic [CW-1:0]    w_ext, w_eff, c_ext;
  logic [CHW-1:0]   h_ext, h_eff, r_ext;
  logic             last_col, last_row, produce, fe;
  logic             in_acc, adv1;

  // stage 1
  logic             v1_q, prod1_q, fe1_q;
  logic [COL_W-1:0] c1_q;
  logic [PIX_W-1:0] up_q, mid_q, right_q, down_q, mid_prev_q;

  // out-of-range sizes act as the nearest legal size
  always_comb begin
    w_ext = CW'(frame_width_i);
    h_ext = CHW'(frame_height_i);
    if (w_ext < CW'(MIN_SIZE)) begin
      w_eff = CW'(MIN_SIZE);
    end else if (w_ext > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext < CHW'(MIN_SIZE)) begin
      h_eff = CHW'(MIN_SIZE);
    end else if (h_ext > CHW'(MAX_HEIGHT)) begin
      h_eff = CHW'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
  end

  assign c_ext    = CW'(col_q);
  assign r_ext    = CHW'(row_q);
  assign last_col = (c_ext + CW'(1)) >= w_eff;
  assign last_row = (r_ext + CHW'(1)) >= h_eff;
  // pixel (r, c) completes the window centered on (r-1, c)
  assign produce  = (r_ext >= CHW'(2)) && (col_q != '0) && ((c_ext + CW'(1)) < w_eff);
  assign fe       = last_row && ((c_ext + CW'(2)) >= w_eff);
  assign col_nxt  = (col_q == COL_W'(MAX_WIDTH - 1)) ? '0 : col_q + COL_W'(1);

  assign adv1       = v1_q && (!prod1_q || win_ready_i);
  assign in_ready_o = !v1_q || adv1;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (in_ready_o) begin
      v1_q <= in_valid_i;
    end
  end

  // read-first: recent row read at the column being overwritten returns the old row
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      up_q              <= older_mem[col_q];
      mid_q             <= recent_mem[col_q];
      right_q           <= recent_mem[col_nxt];
      recent_mem[col_q] <= pixel_i;
      down_q            <= pixel_i;
      c1_q              <= col_q;
      prod1_q           <= produce;
      fe1_q             <= fe;
    end
    if (adv1) begin
      older_mem[c1_q] <= mid_q;
      mid_prev_q      <= mid_q;
    end
  end

  assign win_valid_o     = v1_q && prod1_q;
  assign win_o.left      = mid_prev_q;
  assign win_o.right     = right_q;
  assign win_o.up        = up_q;
  assign win_o.down      = down_q;
  assign win_o.frame_end = fe1_q;

endmodule

@@ rtl/cdgm_grad.sv @@
// Differences, squares and sum of squares over three pipeline stages.
`timescale 1ns / 1ps

module cdgm_grad (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           win_valid_i,
  output logic           win_ready_o,
  input  cdgm_pkg::win_t win_i,
  output logic           sum_valid_o,
  input  logic           sum_ready_i,
  output cdgm_pkg::sum_t sum_o
);
  import cdgm_pkg::*;

  logic                     va_q, vb_q, vc_q;
  logic                     rdy_a, rdy_b, rdy_c;
  logic signed [DIFF_W-1:0] dx_q, dy_q;
  logic                     fea_q, feb_q, fec_q;
  logic signed [2*DIFF_W-1:0] sqx, sqy;
  logic [SQ_W-1:0]          sqx_q, sqy_q;
  logic [SUM_W-1:0]         sum_q;

  assign rdy_c       = !vc_q || sum_ready_i;
  assign rdy_b       = !vb_q || rdy_c;
  assign rdy_a       = !va_q || rdy_b;
  assign win_ready_o = rdy_a;

  assign sqx = dx_q * dx_q;
  assign sqy = dy_q * dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= win_valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && win_valid_i) begin
      dx_q  <= $signed({1'b0, win_i.left}) - $signed({1'b0, win_i.right});
      dy_q  <= $signed({1'b0, win_i.up}) - $signed({1'b0, win_i.down});
      fea_q <= win_i.frame_end;
    end
    if (rdy_b && va_q) begin
      // squares are non-negative and below 2^16
      sqx_q <= sqx[SQ_W-1:0];
      sqy_q <= sqy[SQ_W-1:0];
      feb_q <= fea_q;
    end
    if (rdy_c && vb_q) begin
      sum_q <= SUM_W'(sqx_q) + SUM_W'(sqy_q);
      fec_q <= feb_q;
    end
  end

  assign sum_valid_o     = vc_q;
  assign sum_o.sum       = sum_q;
  assign sum_o.frame_end = fec_q;

endmodule

@@ rtl/cdgm_sqrt.sv @@
// Pipelined digit-by-digit integer square root, three result bits per stage.
`timescale 1ns / 1ps

module cdgm_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       sum_valid_i,
  output logic                       sum_ready_o,
  input  cdgm_pkg::sum_t             sum_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [cdgm_pkg::MAG_W-1:0] magnitude_o,
  output logic                       frame_end_o
);
  import cdgm_pkg::*;

  localparam int STAGES = 3;
  localparam int STEPS  = MAG_W / STAGES;
  localparam int REM_W  = MAG_W + 3;

  logic [STAGES-1:0] v_q;
  logic [STAGES-1:0] fe_q;
  logic [REM_W-1:0]  rem_q  [STAGES];
  logic [MAG_W-1:0]  root_q [STAGES];
  logic [RAD_W-1:0]  rad_q  [STAGES];
  logic              stg_rdy [STAGES+1];

  assign stg_rdy[STAGES] = out_ready_i;
  assign sum_ready_o     = stg_rdy[0];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic             v_s, fe_s;
    logic [REM_W-1:0] rem_s, rem_n;
    logic [MAG_W-1:0] root_s, root_n;
    logic [RAD_W-1:0] rad_s, rad_n;

    if (k == 0) begin : g_first
      assign v_s    = sum_valid_i;
      assign fe_s   = sum_i.frame_end;
      assign rem_s  = '0;
      assign root_s = '0;
      assign rad_s  = RAD_W'(sum_i.sum);
    end else begin : g_next
      assign v_s    = v_q[k-1];
      assign fe_s   = fe_q[k-1];
      assign rem_s  = rem_q[k-1];
      assign root_s = root_q[k-1];
      assign rad_s  = rad_q[k-1];
    end

    assign stg_rdy[k] = !v_q[k] || stg_rdy[k+1];

    always_comb begin
      logic [REM_W-1:0] cur;
      logic [REM_W-1:0] trial;
      rem_n  = rem_s;
      root_n = root_s;
      rad_n  = rad_s;
      for (int i = 0; i < STEPS; i++) begin
        cur   = {rem_n[REM_W-3:0], rad_n[RAD_W-1 -: 2]};
        trial = REM_W'({root_n, 2'b01});
        if (cur >= trial) begin
          rem_n  = cur - trial;
          root_n = {root_n[MAG_W-2:0], 1'b1};
        end else begin
          rem_n  = cur;
          root_n = {root_n[MAG_W-2:0], 1'b0};
        end
        rad_n = {rad_n[RAD_W-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (stg_rdy[k]) begin
        v_q[k] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (stg_rdy[k] && v_s) begin
        rem_q[k]  <= rem_n;
        root_q[k] <= root_n;
        rad_q[k]  <= rad_n;
        fe_q[k]   <= fe_s;
      end
    end
  end

  assign out_valid_o = v_q[STAGES-1];
  assign magnitude_o = root_q[STAGES-1];
  assign frame_end_o = fe_q[STAGES-1];

endmodule

@@ rtl/central_difference_gradient_magnitude.sv @@
// Top level: frame size registers, line buffer, gradient and square-root pipelines.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+---------------------------
//  pixel in | in_valid_i / in_ready_o        | pixel_i
//  result   | out_valid_o / out_ready_i      | magnitude_o, frame_end_o
//  config   | cfg_we_i (write only, no wait) | cfg_idx_i, cfg_data_i
//
// One pixel per clock. A result passes, after its pixel request is taken, through
// one line-memory read stage, three gradient stages and three root stages.
// Border pixels are dropped after the memory stage. Every stage holds its data
// while the next one is full, so out_ready_i low backs up stage by stage.
// Reset clears counters and valid bits; line memories are not cleared.
`timescale 1ns / 1ps

module central_difference_gradient_magnitude #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [cdgm_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [cdgm_pkg::PIX_W-1:0] pixel_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [cdgm_pkg::MAG_W-1:0] magnitude_o,
  output logic                       frame_end_o
);
  import cdgm_pkg::*;

  logic [CFG_W-1:0] frame_width_q, frame_height_q;
  logic             win_valid, win_ready, sum_valid, sum_ready;
  win_t             win;
  sum_t             sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cdgm_line_buf #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_line_buf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_i        (pixel_i),
    .win_valid_o    (win_valid),
    .win_ready_i    (win_ready),
    .win_o          (win)
  );

  cdgm_grad u_grad (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_valid_i (win_valid),
    .win_ready_o (win_ready),
    .win_i       (win),
    .sum_valid_o (sum_valid),
    .sum_ready_i (sum_ready),
    .sum_o       (sum)
  );

  cdgm_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sum_valid_i (sum_valid),
    .sum_ready_o (sum_ready),
    .sum_i       (sum),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .magnitude_o (magnitude_o),
    .frame_end_o (frame_end_o)
  );

endmodule
